>>> design/pacs_pkg.sv
package pacs_pkg;

  // Read length limit; bases past it are counted by neither position nor score.
  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);

  // Field and register widths
  localparam int unsigned BASE_W  = 3;
  localparam int unsigned PEN_W   = 3;
  localparam int unsigned RATIO_W = 4;
  localparam int unsigned LIM_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Running score: signed, wide enough for the lowest score reachable before the stop
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned LHS_W   = SCORE_W + RATIO_W + 1;
  localparam int unsigned RHS_W   = POS_W + RATIO_W;
  localparam int unsigned CMP_W   = (LHS_W > RHS_W + 1) ? LHS_W : RHS_W + 1;
  localparam int unsigned DIFF_W  = ((SCORE_W > POS_W + 1) ? SCORE_W : POS_W + 1) + 1;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MISMATCH_PENALTY = 3'd0,
    REG_RATIO_NUM        = 3'd1,
    REG_RATIO_DEN        = 3'd2,
    REG_DROP_LIMIT       = 3'd3,
    REG_MIN_SCORE        = 3'd4,
    REG_MIN_LENGTH       = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [PEN_W-1:0]   RST_MISMATCH_PENALTY = 3'd2;
  localparam logic [RATIO_W-1:0] RST_RATIO_NUM        = 4'd7;
  localparam logic [RATIO_W-1:0] RST_RATIO_DEN        = 4'd10;
  localparam logic [LIM_W-1:0]   RST_DROP_LIMIT       = 12'd27;
  localparam logic [LIM_W-1:0]   RST_MIN_SCORE        = 12'd20;
  localparam logic [LIM_W-1:0]   RST_MIN_LENGTH       = 12'd20;

endpackage

>>> design/poly_a_tail_clip_scorer.sv
// Poly-A tail clip scorer.
//
// Input channel (in_valid/in_ready): one base per transfer, starting at the
// read's 3' end, with in_last_base high on the read's final base. Result
// channel (out_valid/out_ready): one clip length per read, produced by the
// transfer that carries in_last_base.
//
// Throughput is one base per cycle while no result waits for the receiver:
// the score update, ratio test and drop test are a single small
// multiply-and-compare that closes in the cycle the base is taken. out_valid
// rises in the cycle after the last base's transfer, set by the output register.
//
// A stalled receiver holds the output register, and in_ready drops while a
// result waits, so no base is taken until that result leaves. A base is
// still taken in the cycle the held result transfers.
//
// Reset (synchronous, rst_n low) clears the per-read state and out_valid
// and loads the default configuration. Write configuration through
// cfg_we/cfg_index/cfg_wdata only while no read is in progress.
module poly_a_tail_clip_scorer (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pacs_pkg::BASE_W-1:0]   in_base_code,
  input  logic                          in_last_base,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pacs_pkg::POS_W-1:0]    out_clip_length,

  input  logic                          cfg_we,
  input  logic [pacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pacs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [pacs_pkg::POS_W-1:0] MaxPos = pacs_pkg::POS_W'(pacs_pkg::MAX_LEN);

  // Configuration registers
  logic [pacs_pkg::PEN_W-1:0]   penalty_r;
  logic [pacs_pkg::RATIO_W-1:0] num_r;
  logic [pacs_pkg::RATIO_W-1:0] den_r;
  logic [pacs_pkg::LIM_W-1:0]   drop_r;
  logic [pacs_pkg::LIM_W-1:0]   min_score_r;
  logic [pacs_pkg::LIM_W-1:0]   min_len_r;

  // Per-read state
  logic signed [pacs_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic        [pacs_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic        [pacs_pkg::POS_W-1:0]   best_len_r, best_len_nxt;
  logic signed [pacs_pkg::SCORE_W-1:0] best_score_r, best_score_nxt;
  logic                                stopped_r, stopped_nxt;

  // Output register
  logic                         out_valid_r;
  logic [pacs_pkg::POS_W-1:0]   clip_r, clip_nxt;

  logic in_xfer;

  // Scoring datapath
  logic signed [pacs_pkg::SCORE_W-1:0] score_step;
  logic signed [pacs_pkg::CMP_W-1:0]   lhs;
  logic signed [pacs_pkg::CMP_W-1:0]   rhs;
  logic        [pacs_pkg::RHS_W-1:0]   pos_prod;
  logic signed [pacs_pkg::DIFF_W-1:0]  drop_diff;
  logic                                is_a;
  logic                                scoring;

  assign in_ready        = !out_valid_r || out_ready;
  assign in_xfer         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_clip_length = clip_r;

  always_comb begin
    is_a    = (in_base_code == pacs_pkg::BASE_A);
    pos_nxt = pos_r;
    scoring = 1'b0;
    if (pos_r < MaxPos) begin
      pos_nxt = pos_r + pacs_pkg::POS_W'(1);
      scoring = !stopped_r;
    end

    if (is_a) begin
      score_step = score_r + pacs_pkg::SCORE_W'(1);
    end else begin
      score_step = score_r - $signed({{(pacs_pkg::SCORE_W - pacs_pkg::PEN_W){1'b0}}, penalty_r});
    end

    // Ratio test: score * den >= pos * num
    lhs      = pacs_pkg::CMP_W'(score_step)
             * $signed({{(pacs_pkg::CMP_W - pacs_pkg::RATIO_W){1'b0}}, den_r});
    pos_prod = pacs_pkg::RHS_W'(pos_nxt) * pacs_pkg::RHS_W'(num_r);
    rhs      = $signed({{(pacs_pkg::CMP_W - pacs_pkg::RHS_W){1'b0}}, pos_prod});

    // Drop test: pos - score > drop limit
    drop_diff = $signed({{(pacs_pkg::DIFF_W - pacs_pkg::POS_W){1'b0}}, pos_nxt})
              - pacs_pkg::DIFF_W'(score_step);

    score_nxt      = score_r;
    best_len_nxt   = best_len_r;
    best_score_nxt = best_score_r;
    stopped_nxt    = stopped_r;
    if (scoring) begin
      score_nxt = score_step;
      if (is_a) begin
        if (lhs >= rhs) begin
          best_len_nxt   = pos_nxt;
          best_score_nxt = score_step;
        end
      end else if (drop_diff >
                   $signed({{(pacs_pkg::DIFF_W - pacs_pkg::LIM_W){1'b0}}, drop_r})) begin
        stopped_nxt = 1'b1;
      end
    end

    // Clip length: drop short reads and weak tails
    clip_nxt = best_len_nxt;
    if (pos_nxt < pacs_pkg::POS_W'(min_len_r)) begin
      clip_nxt = '0;
    end
    if (best_score_nxt <
        $signed({{(pacs_pkg::SCORE_W - pacs_pkg::LIM_W){1'b0}}, min_score_r})) begin
      clip_nxt = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r   <= pacs_pkg::RST_MISMATCH_PENALTY;
      num_r       <= pacs_pkg::RST_RATIO_NUM;
      den_r       <= pacs_pkg::RST_RATIO_DEN;
      drop_r      <= pacs_pkg::RST_DROP_LIMIT;
      min_score_r <= pacs_pkg::RST_MIN_SCORE;
      min_len_r   <= pacs_pkg::RST_MIN_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pacs_pkg::REG_MISMATCH_PENALTY: penalty_r   <= cfg_wdata[pacs_pkg::PEN_W-1:0];
        pacs_pkg::REG_RATIO_NUM:        num_r       <= cfg_wdata[pacs_pkg::RATIO_W-1:0];
        pacs_pkg::REG_RATIO_DEN:        den_r       <= cfg_wdata[pacs_pkg::RATIO_W-1:0];
        pacs_pkg::REG_DROP_LIMIT:       drop_r      <= cfg_wdata[pacs_pkg::LIM_W-1:0];
        pacs_pkg::REG_MIN_SCORE:        min_score_r <= cfg_wdata[pacs_pkg::LIM_W-1:0];
        pacs_pkg::REG_MIN_LENGTH:       min_len_r   <= cfg_wdata[pacs_pkg::LIM_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Per-read state: update on every base taken, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r      <= '0;
      pos_r        <= '0;
      best_len_r   <= '0;
      best_score_r <= '0;
      stopped_r    <= 1'b0;
    end else if (in_xfer) begin
      if (in_last_base) begin
        score_r      <= '0;
        pos_r        <= '0;
        best_len_r   <= '0;
        best_score_r <= '0;
        stopped_r    <= 1'b0;
      end else begin
        score_r      <= score_nxt;
        pos_r        <= pos_nxt;
        best_len_r   <= best_len_nxt;
        best_score_r <= best_score_nxt;
        stopped_r    <= stopped_nxt;
      end
    end
  end

  // Output register: load on a read's last base, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_last_base) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_last_base) begin
      clip_r <= clip_nxt;
    end
  end

endmodule
